// File: rtl/correlation_cost_volume_forward_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the correlation cost volume block
// ---------------------------------------------------------------------------
`ifndef CORRELATION_COST_VOLUME_FORWARD_ASSERT_SVH
`define CORRELATION_COST_VOLUME_FORWARD_ASSERT_SVH

// same-cycle implication
`define CCV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CCV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ccv_pkg.sv
// ---------------------------------------------------------------------------
// ccv_pkg
// Shared types and constants of the correlation cost volume block.
// ---------------------------------------------------------------------------
package ccv_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GRID,
    ST_IDX,
    ST_TAPS,
    ST_DRAIN,
    ST_MEAN,
    ST_OUT
  } ccv_state_t;

  localparam logic [2:0] REG_KRAD   = 3'd0;
  localparam logic [2:0] REG_MAXD   = 3'd1;
  localparam logic [2:0] REG_CSTR   = 3'd2;
  localparam logic [2:0] REG_DSTR   = 3'd3;
  localparam logic [2:0] REG_PAD    = 3'd4;
  localparam logic [2:0] REG_MULT   = 3'd5;
  localparam logic [2:0] REG_WIDTH  = 3'd6;
  localparam logic [2:0] REG_HEIGHT = 3'd7;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  localparam int         DIV_W     = 48;
  localparam logic [5:0] DIV_STEPS = 6'd48;

endpackage

// File: rtl/ccv_ram.sv
// ---------------------------------------------------------------------------
// ccv_ram
// Generic RAM, one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module ccv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/correlation_cost_volume_forward.sv
// ---------------------------------------------------------------------------
// correlation_cost_volume_forward
// Correlation of two feature maps held in two on-chip stores.
// ---------------------------------------------------------------------------
// channel  | handshake                 | payload
// input    | start / busy              | in_command .. in_displacement_index
// result   | out_valid (one cycle)     | out_correlation
// config   | psel penable pwrite pready| paddr pwdata prdata
//
// A load writes both stores at its accept edge when its position and channel
// are in range, and does not raise busy. A compute holds busy from its accept
// edge while one shared restoring divider (48 steps) runs three times, the tap
// walk reads one word per store per cycle, the read pipeline drains and the
// result state follows. An index outside the grid skips the taps and the mean.
// Reset is synchronous; stores are not cleared. The result strobe lasts one
// cycle and cannot be stalled.
// ---------------------------------------------------------------------------
module correlation_cost_volume_forward
  import ccv_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int CHANNELS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_command,
  input  logic [5:0]         in_pos_x,
  input  logic [5:0]         in_pos_y,
  input  logic [3:0]         in_channel_index,
  input  logic signed [15:0] in_first_value,
  input  logic signed [15:0] in_second_value,
  input  logic [10:0]        in_displacement_index,
  output logic               out_valid,
  output logic signed [31:0] out_correlation,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int PLANE = MAX_WIDTH * MAX_HEIGHT;
  localparam int DEPTH = PLANE * CHANNELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CHW-1:0] CH_LAST = CHW'(CHANNELS - 1);

  // configuration
  logic [1:0] krad_r;
  logic [4:0] maxd_r;
  logic [3:0] cstr_r;
  logic [3:0] dstr_r;
  logic [4:0] pad_r;
  logic       mult_r;
  logic [6:0] width_r;
  logic [6:0] height_r;

  logic cfg_we;
  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      krad_r   <= 2'd0;
      maxd_r   <= 5'd4;
      cstr_r   <= 4'd1;
      dstr_r   <= 4'd1;
      pad_r    <= 5'd4;
      mult_r   <= 1'b1;
      width_r  <= 7'd64;
      height_r <= 7'd64;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        REG_KRAD:   krad_r   <= pwdata[1:0];
        REG_MAXD:   maxd_r   <= pwdata[4:0];
        REG_CSTR:   cstr_r   <= pwdata[3:0];
        REG_DSTR:   dstr_r   <= pwdata[3:0];
        REG_PAD:    pad_r    <= pwdata[4:0];
        REG_MULT:   mult_r   <= pwdata[0];
        REG_WIDTH:  width_r  <= pwdata[6:0];
        REG_HEIGHT: height_r <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_KRAD:   prdata = 32'(krad_r);
      REG_MAXD:   prdata = 32'(maxd_r);
      REG_CSTR:   prdata = 32'(cstr_r);
      REG_DSTR:   prdata = 32'(dstr_r);
      REG_PAD:    prdata = 32'(pad_r);
      REG_MULT:   prdata = 32'(mult_r);
      REG_WIDTH:  prdata = 32'(width_r);
      REG_HEIGHT: prdata = 32'(height_r);
      default:    prdata = 32'd0;
    endcase
  end

  // derived configuration
  logic [3:0]  s2eff;
  logic [12:0] w_eff, h_eff;
  logic [2:0]  kmax;
  logic [5:0]  ksq;
  logic [DIV_W-1:0] terms;
  assign s2eff = (dstr_r == 4'd0) ? 4'd1 : dstr_r;
  assign w_eff = (13'(width_r) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(width_r);
  assign h_eff = (13'(height_r) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(height_r);
  assign kmax  = {krad_r, 1'b0};
  assign ksq   = 6'(({1'b0, kmax} + 4'd1) * ({1'b0, kmax} + 4'd1));
  assign terms = DIV_W'(ksq) * DIV_W'(CHANNELS);

  // state
  ccv_state_t state_r, state_nxt;
  logic accept, load_ok, div_done;
  logic [AW-1:0] ld_addr;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign load_ok = (int'(in_pos_x) < MAX_WIDTH) && (int'(in_pos_y) < MAX_HEIGHT) &&
                   (int'(in_channel_index) < CHANNELS);
  assign ld_addr = AW'(in_channel_index) * AW'(PLANE) + AW'(in_pos_y) * AW'(MAX_WIDTH) +
                   AW'(in_pos_x);

  // shared restoring divider
  logic [DIV_W-1:0] div_num_r, div_rem_r, div_den_r;
  logic [5:0]       div_cnt_r;
  logic [DIV_W:0]   rem_sh, rem_sub;
  logic             div_ge;
  assign rem_sh   = {div_rem_r, div_num_r[DIV_W-1]};
  assign div_ge   = rem_sh >= {1'b0, div_den_r};
  assign rem_sub  = rem_sh - {1'b0, div_den_r};
  assign div_done = (div_cnt_r == 6'd0);

  // compute registers
  logic [5:0]  px_r, py_r;
  logic [10:0] didx_r;
  logic [4:0]  gr_r;
  logic [5:0]  gw;
  logic signed [12:0] bx_r, by_r, ox_r, oy_r;
  logic [2:0]  ti_r, tj_r;
  logic [CHW-1:0] ch_r;
  logic        tap_last;
  logic        out_of_grid;
  logic signed [12:0] dx, dy, bx_new, by_new;

  assign gw = {gr_r, 1'b1};
  assign out_of_grid = div_num_r >= DIV_W'(gw);
  assign dx = $signed(13'(div_rem_r[5:0])) - $signed(13'(gr_r));
  assign dy = $signed(13'(div_num_r[10:0])) - $signed(13'(gr_r));
  assign bx_new = $signed(13'(px_r * cstr_r)) + $signed(13'(maxd_r)) - $signed(13'(pad_r));
  assign by_new = $signed(13'(py_r * cstr_r)) + $signed(13'(maxd_r)) - $signed(13'(pad_r));
  assign tap_last = (ti_r == kmax) && (tj_r == kmax) && (ch_r == CH_LAST);

  // tap addresses
  logic signed [12:0] x1, y1, x2, y2;
  logic ok1, ok2;
  logic [AW-1:0] ra1, ra2;
  assign x1  = bx_r + $signed(13'(ti_r));
  assign y1  = by_r + $signed(13'(tj_r));
  assign x2  = x1 + ox_r;
  assign y2  = y1 + oy_r;
  assign ok1 = !x1[12] && !y1[12] && ($unsigned(x1) < w_eff) && ($unsigned(y1) < h_eff);
  assign ok2 = !x2[12] && !y2[12] && ($unsigned(x2) < w_eff) && ($unsigned(y2) < h_eff);
  assign ra1 = AW'(ch_r) * AW'(PLANE) + AW'(y1[YW-1:0]) * AW'(MAX_WIDTH) + AW'(x1[XW-1:0]);
  assign ra2 = AW'(ch_r) * AW'(PLANE) + AW'(y2[YW-1:0]) * AW'(MAX_WIDTH) + AW'(x2[XW-1:0]);

  // stores
  logic ram_we;
  logic [15:0] rd1, rd2;
  assign ram_we = accept && (in_command == CMD_LOAD) && load_ok;

  ccv_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_first (
    .clk(clk), .we(ram_we), .waddr(ld_addr), .wdata(in_first_value),
    .raddr(ra1), .rdata(rd1)
  );

  ccv_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_second (
    .clk(clk), .we(ram_we), .waddr(ld_addr), .wdata(in_second_value),
    .raddr(ra2), .rdata(rd2)
  );

  // read/term/accumulate pipeline
  logic iss_v_r, iss_ok1_r, iss_ok2_r, iss_last_r;
  logic term_v_r, term_last_r, acc_done_r;
  logic signed [33:0] term_r;
  logic signed [DIV_W-1:0] sum_r;
  logic signed [16:0] a_s, b_s, d_s;
  assign a_s = iss_ok1_r ? 17'($signed(rd1)) : 17'sd0;
  assign b_s = iss_ok2_r ? 17'($signed(rd2)) : 17'sd0;
  assign d_s = a_s - b_s;

  logic neg_r;
  logic signed [31:0] res_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept && in_command == CMD_COMPUTE) state_nxt = ST_GRID;
      ST_GRID:  if (div_done) state_nxt = ST_IDX;
      ST_IDX:   if (div_done) state_nxt = out_of_grid ? ST_OUT : ST_TAPS;
      ST_TAPS:  if (tap_last) state_nxt = ST_DRAIN;
      ST_DRAIN: if (acc_done_r) state_nxt = ST_MEAN;
      ST_MEAN:  if (div_done) state_nxt = ST_OUT;
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r   <= 6'd0;
      iss_v_r     <= 1'b0;
      term_v_r    <= 1'b0;
      term_last_r <= 1'b0;
      iss_last_r  <= 1'b0;
      acc_done_r  <= 1'b0;
    end else begin
      iss_v_r     <= (state_r == ST_TAPS);
      iss_last_r  <= (state_r == ST_TAPS) && tap_last;
      term_v_r    <= iss_v_r;
      term_last_r <= iss_last_r;
      if (state_r == ST_IDLE) begin
        acc_done_r <= 1'b0;
      end else if (term_last_r) begin
        acc_done_r <= 1'b1;
      end
      if (!div_done) begin
        div_cnt_r <= div_cnt_r - 6'd1;
      end
      if (accept && in_command == CMD_COMPUTE) begin
        div_cnt_r <= DIV_STEPS;
      end else if (state_r == ST_GRID && div_done) begin
        div_cnt_r <= DIV_STEPS;
      end else if (state_r == ST_DRAIN && acc_done_r) begin
        div_cnt_r <= DIV_STEPS;
      end
    end
  end

  always_ff @(posedge clk) begin
    iss_ok1_r <= ok1;
    iss_ok2_r <= ok2;
    term_r    <= mult_r ? 34'(a_s * b_s) : 34'(d_s[16] ? -d_s : d_s);
    if (!div_done) begin
      div_rem_r <= div_ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      div_num_r <= {div_num_r[DIV_W-2:0], div_ge};
    end
    if (term_v_r) begin
      sum_r <= sum_r + DIV_W'(term_r);
    end
    unique case (state_r)
      ST_IDLE: begin
        px_r   <= in_pos_x;
        py_r   <= in_pos_y;
        didx_r <= in_displacement_index;
        div_num_r <= DIV_W'(maxd_r);
        div_den_r <= DIV_W'(s2eff);
        div_rem_r <= '0;
      end
      ST_GRID: begin
        if (div_done) begin
          gr_r      <= div_num_r[4:0];
          div_num_r <= DIV_W'(didx_r);
          div_den_r <= DIV_W'({div_num_r[4:0], 1'b1});
          div_rem_r <= '0;
        end
      end
      ST_IDX: begin
        if (div_done) begin
          res_r <= 32'sd0;
          bx_r  <= bx_new;
          by_r  <= by_new;
          ox_r  <= 13'(dx * $signed(13'(s2eff)));
          oy_r  <= 13'(dy * $signed(13'(s2eff)));
          ti_r  <= 3'd0;
          tj_r  <= 3'd0;
          ch_r  <= '0;
          sum_r <= '0;
        end
      end
      ST_TAPS: begin
        if (ch_r == CH_LAST) begin
          ch_r <= '0;
          if (tj_r == kmax) begin
            tj_r <= 3'd0;
            ti_r <= ti_r + 3'd1;
          end else begin
            tj_r <= tj_r + 3'd1;
          end
        end else begin
          ch_r <= ch_r + CHW'(1);
        end
      end
      ST_DRAIN: begin
        if (acc_done_r) begin
          neg_r     <= sum_r[DIV_W-1];
          div_num_r <= sum_r[DIV_W-1] ? DIV_W'(-sum_r) : DIV_W'(sum_r);
          div_den_r <= terms;
          div_rem_r <= '0;
        end
      end
      ST_MEAN: begin
        if (div_done) begin
          if (!neg_r && div_num_r > DIV_W'(32'h7FFF_FFFF)) begin
            res_r <= 32'sh7FFF_FFFF;
          end else if (neg_r && div_num_r > DIV_W'(33'h0_8000_0000)) begin
            res_r <= 32'sh8000_0000;
          end else begin
            res_r <= neg_r ? -$signed(div_num_r[31:0]) : $signed(div_num_r[31:0]);
          end
        end
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  assign out_valid       = (state_r == ST_OUT);
  assign out_correlation = res_r;

  `include "correlation_cost_volume_forward_assert.svh"

  `CCV_ASSERT_NXT(a_one_strobe, out_valid, !out_valid, "result strobe longer than one cycle")
  `CCV_ASSERT_IMP(a_we_idle, ram_we, state_r == ST_IDLE, "store written during compute")
  `CCV_ASSERT_NXT(a_compute_busy, accept && in_command == CMD_COMPUTE, busy,
                  "compute accepted without going busy")
  `CCV_ASSERT_IMP(a_div_owner, !div_done,
                  state_r == ST_GRID || state_r == ST_IDX || state_r == ST_MEAN,
                  "divider running outside a divide state")

endmodule
